// ===== hw/rtl/apau_pkg.sv =====
package apau_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ADAPT,
    ST_MAC,
    ST_FINAL
  } apau_state_t;

  localparam logic [4:0]  ADDR_WIDE_MODE = 5'd0;
  localparam logic [18:0] SLOW_RESET     = 19'd34816;
  localparam logic [12:0] FAST_MIN       = 13'd544;
  localparam logic [12:0] FAST_MAX       = 13'd5120;
  localparam logic [15:0] HIST_RESET     = 16'h0020;
  localparam logic [15:0] FLOAT_NEG_ZERO = 16'hFC20;
  localparam logic [2:0]  MAC_LAST       = 3'd7;
  localparam logic [2:0]  NUM_ZEROS      = 3'd6;

endpackage

// ===== hw/rtl/adpcm_predictor_adaptation_unit.sv =====
// G.721/G.723 ADPCM adaptation unit: holds the scale factor, speed control, tone and transition
// detector and the two-pole/six-zero predictor state. Each input beat carries the quantized
// difference, reconstructed signal, difference plus zero estimate, scale multiplier and speed
// term of one sample; the unit adapts its state and returns one result beat with the step size
// for the next sample and the zero and pole predictor sums. Each item goes through states
// forming the current step size and adapting all state, a sweep of one shared floating-point
// multiplier over the eight predictor products in turn, and a state forming the next step
// size. A new item is taken only once the previous result has been taken. After reset the
// state gives step size 544 and both sums 0. wide_code_mode (APB address 0) selects the 40 kbit
// zero coefficient leak; the user must write it only while the unit is idle (not enforced).
module adpcm_predictor_adaptation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_diff_quantized,
  input  logic signed [15:0] in_recon_signal,
  input  logic signed [16:0] in_diff_plus_zero_est,
  input  logic signed [13:0] in_scale_multiplier,
  input  logic        [11:0] in_speed_term,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [12:0] out_quant_step,
  output logic signed [18:0] out_zero_sum,
  output logic signed [16:0] out_pole_sum,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import apau_pkg::*;

  function automatic logic [12:0] step_of(logic [18:0] yl, logic [12:0] yu, logic [9:0] ap);
    logic [12:0]        y;
    logic signed [13:0] dif;
    logic signed [21:0] p;
    logic signed [21:0] q;
    logic signed [14:0] r;
    y   = yl[18:6];
    dif = $signed({1'b0, yu}) - $signed({1'b0, y});
    p   = dif * $signed({1'b0, ap[9:2]});
    if (dif > 14'sd0) begin
      q = p >>> 6;
    end else if (dif < 14'sd0) begin
      q = (p + 22'sd63) >>> 6;
    end else begin
      q = 22'sd0;
    end
    r = $signed({2'b00, y}) + q[14:0];
    if (ap >= 10'd256) begin
      return yu;
    end
    return r[12:0];
  endfunction

  function automatic logic [15:0] to_float(logic neg, logic [14:0] mag);
    logic [3:0]  e;
    logic [20:0] sh;
    logic [15:0] f;
    e = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (mag[i]) e = 4'(i + 1);
    end
    sh = {mag, 6'b0} >> e;
    f  = {6'b0, e, 6'b0} + {10'b0, sh[5:0]};
    if (mag == 15'd0) begin
      return neg ? FLOAT_NEG_ZERO : HIST_RESET;
    end
    return neg ? f - 16'h0400 : f;
  endfunction

  function automatic logic signed [15:0] fmul(logic signed [13:0] an, logic [15:0] srn);
    logic [13:0]        neg_an;
    logic [12:0]        mag;
    logic [3:0]         e;
    logic signed [4:0]  ex;
    logic signed [4:0]  nx;
    logic [5:0]         mant;
    logic signed [5:0]  wex;
    logic signed [5:0]  nw;
    logic [11:0]        prod;
    logic [11:0]        rnd;
    logic [7:0]         wm;
    logic [22:0]        shl;
    logic [14:0]        r;
    neg_an = 14'(-an);
    mag    = (an > 14'sd0) ? an[12:0] : neg_an[12:0];
    e = 4'd0;
    for (int i = 0; i < 13; i++) begin
      if (mag[i]) e = 4'(i + 1);
    end
    ex = $signed({1'b0, e}) - 5'sd6;
    nx = -ex;
    if (mag == 13'd0) begin
      mant = 6'd32;
    end else if (ex >= 5'sd0) begin
      mant = 6'(mag >> ex[2:0]);
    end else begin
      mant = 6'(mag << nx[2:0]);
    end
    wex  = $signed({ex[4], ex}) + $signed({2'b00, srn[9:6]}) - 6'sd13;
    nw   = -wex;
    prod = {6'b0, mant} * {6'b0, srn[5:0]};
    rnd  = prod + 12'd48;
    wm   = rnd[11:4];
    shl  = {15'b0, wm} << wex[3:0];
    if (wex >= 6'sd0) begin
      r = shl[14:0];
    end else begin
      r = 15'({7'b0, wm} >> nw[4:0]);
    end
    if ((an < 14'sd0) != srn[15]) begin
      return -$signed({1'b0, r});
    end
    return $signed({1'b0, r});
  endfunction

  apau_state_t state_r, state_nxt;
  logic [2:0]  k_r;
  logic        out_valid_r;
  logic        mode_r;

  logic signed [15:0] dq_r, sr_r;
  logic signed [16:0] dqsez_r;
  logic signed [13:0] wi_r;
  logic        [11:0] fi_r;
  logic        [12:0] y_r;

  logic [18:0] slow_r, slow_nxt;
  logic [12:0] fast_r, fast_nxt;
  logic signed [15:0] se_r, se_nxt, le_r, le_nxt;
  logic [9:0]  sp_r, sp_nxt;
  logic signed [15:0] pole_r [2];
  logic signed [15:0] pole_nxt [2];
  logic signed [15:0] zero_r [6];
  logic signed [15:0] zero_nxt [6];
  logic        ps_r [2];
  logic [15:0] sh_r [2];
  logic [15:0] dh_r [6];
  logic [15:0] dh0_nxt, sh0_nxt;
  logic        tone_r, tone_nxt;

  logic signed [18:0] zs_r;
  logic signed [16:0] pacc_r;
  logic [12:0]        out_step_r;
  logic signed [18:0] out_zs_r;
  logic signed [16:0] out_ps_r;

  logic        ld_in, do_step, do_adapt, do_mac, do_final;
  logic [12:0] y_cur;
  logic signed [15:0] mac_coef;
  logic [15:0]        mac_hist;
  logic signed [15:0] mac_prod;

  function automatic logic [3:0] sl_ylint();
    return slow_r[18:15];
  endfunction

  assign y_cur = step_of(slow_r, fast_r, sp_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_ready) state_nxt = ST_STEP;
      ST_STEP:  state_nxt = ST_ADAPT;
      ST_ADAPT: state_nxt = ST_MAC;
      ST_MAC:   if (k_r == MAC_LAST) state_nxt = ST_FINAL;
      ST_FINAL: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    do_step  = 1'b0;
    do_adapt = 1'b0;
    do_mac   = 1'b0;
    do_final = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = !out_valid_r;
      ST_STEP:  do_step  = 1'b1;
      ST_ADAPT: do_adapt = 1'b1;
      ST_MAC:   do_mac   = 1'b1;
      ST_FINAL: do_final = 1'b1;
      default:  in_ready = 1'b0;
    endcase
  end

  assign ld_in = in_valid && in_ready;

  always_comb begin
    logic [14:0]        mag;
    logic               pk0, nz, pks1, tr;
    logic [15:0]        thr;
    logic [16:0]        tsum;
    logic [15:0]        dqthr;
    logic signed [14:0] fdiff, fsh;
    logic signed [15:0] fsum;
    logic [19:0]        ssum;
    logic signed [17:0] a2p, a0n, a1ul, fa1;
    logic [15:0]        a2w;
    logic signed [16:0] b;
    logic signed [16:0] ed, esum;
    logic signed [17:0] ld, lsum;
    logic signed [18:0] d, dthr;
    logic signed [10:0] inc;
    mag   = dq_r[14:0];
    pk0   = dqsez_r[16];
    nz    = (dqsez_r != 17'sd0);
    thr   = (sl_ylint() > 4'd9) ? 16'd31744 : ({10'b0, 1'b1, slow_r[14:10]} << sl_ylint());
    tsum  = {1'b0, thr} + {2'b0, thr[15:1]};
    dqthr = tsum[16:1];
    tr    = tone_r && ({1'b0, mag} > dqthr);

    fdiff = $signed({wi_r[13], wi_r}) - $signed({2'b00, y_r});
    fsh   = fdiff >>> 5;
    fsum  = $signed({3'b000, y_r}) + $signed({fsh[14], fsh});
    if (fsum < $signed({3'b000, FAST_MIN})) fast_nxt = FAST_MIN;
    else if (fsum > $signed({3'b000, FAST_MAX})) fast_nxt = FAST_MAX;
    else fast_nxt = fsum[12:0];
    ssum     = {1'b0, slow_r} + {7'b0, fast_nxt} - (({1'b0, slow_r} + 20'd63) >> 6);
    slow_nxt = ssum[18:0];

    pks1 = pk0 ^ ps_r[0];
    a2p  = $signed({{2{pole_r[1][15]}}, pole_r[1]}) -
           $signed({{2{pole_r[1][15]}}, pole_r[1] >>> 7});
    fa1  = pks1 ? $signed({{2{pole_r[0][15]}}, pole_r[0]})
                : -$signed({{2{pole_r[0][15]}}, pole_r[0]});
    if (nz) begin
      if (fa1 < -18'sd8191) a2p = a2p - 18'sd256;
      else if (fa1 > 18'sd8191) a2p = a2p + 18'sd255;
      else a2p = a2p + (fa1 >>> 5);
      if (pk0 ^ ps_r[1]) begin
        if (a2p <= -18'sd12160) a2p = -18'sd12288;
        else if (a2p >= 18'sd12416) a2p = 18'sd12288;
        else a2p = a2p - 18'sd128;
      end else begin
        if (a2p <= -18'sd12416) a2p = -18'sd12288;
        else if (a2p >= 18'sd12160) a2p = 18'sd12288;
        else a2p = a2p + 18'sd128;
      end
    end
    a2w  = a2p[15:0];
    a0n  = $signed({{2{pole_r[0][15]}}, pole_r[0]}) -
           $signed({{2{pole_r[0][15]}}, pole_r[0] >>> 8});
    if (nz) a0n = pks1 ? a0n - 18'sd192 : a0n + 18'sd192;
    a1ul = 18'sd15360 - $signed({{2{a2w[15]}}, a2w});
    if (a0n < -a1ul) a0n = -a1ul;
    else if (a0n > a1ul) a0n = a1ul;

    for (int i = 0; i < 6; i++) begin
      b = $signed({zero_r[i][15], zero_r[i]});
      b = mode_r ? b - (b >>> 9) : b - (b >>> 8);
      if (mag != 15'd0) begin
        b = (dq_r[15] == dh_r[i][15]) ? b + 17'sd128 : b - 17'sd128;
      end
      zero_nxt[i] = tr ? 16'sd0 : b[15:0];
    end
    pole_nxt[1] = tr ? 16'sd0 : $signed(a2w);
    pole_nxt[0] = tr ? 16'sd0 : a0n[15:0];
    tone_nxt    = tr ? 1'b0 : ($signed(a2w) < -16'sd11776);

    dh0_nxt = to_float(dq_r[15], mag);
    if (sr_r == -16'sd32768) sh0_nxt = FLOAT_NEG_ZERO;
    else if (sr_r < 16'sd0) sh0_nxt = to_float(1'b1, 15'(-sr_r));
    else sh0_nxt = to_float(1'b0, sr_r[14:0]);

    ed     = $signed({5'b0, fi_r}) - $signed({se_r[15], se_r});
    esum   = $signed({se_r[15], se_r}) + (ed >>> 5);
    se_nxt = esum[15:0];
    ld     = $signed({4'b0, fi_r, 2'b00}) - $signed({{2{le_r[15]}}, le_r});
    lsum   = $signed({{2{le_r[15]}}, le_r}) + (ld >>> 7);
    le_nxt = lsum[15:0];
    d      = $signed({se_nxt[15], se_nxt, 2'b00}) - $signed({{3{le_nxt[15]}}, le_nxt});
    if (d < 19'sd0) d = -d;
    dthr   = $signed({{3{le_nxt[15]}}, le_nxt}) >>> 3;
    if (y_r < 13'd1536 || tone_nxt || d >= dthr) inc = (11'sh200 - $signed({1'b0, sp_r})) >>> 4;
    else inc = (-$signed({1'b0, sp_r})) >>> 4;
    sp_nxt = tr ? 10'd256 : sp_r + inc[9:0];
  end

  always_comb begin
    if (k_r < NUM_ZEROS) begin
      mac_coef = zero_r[k_r];
      mac_hist = dh_r[k_r];
    end else begin
      mac_coef = pole_r[~k_r[0]];
      mac_hist = sh_r[~k_r[0]];
    end
    mac_prod = fmul(mac_coef[15:2], mac_hist);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      slow_r      <= SLOW_RESET;
      fast_r      <= FAST_MIN;
      se_r        <= 16'sd0;
      le_r        <= 16'sd0;
      sp_r        <= 10'd0;
      tone_r      <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pole_r[i] <= 16'sd0;
        ps_r[i]   <= 1'b0;
        sh_r[i]   <= HIST_RESET;
      end
      for (int i = 0; i < 6; i++) begin
        zero_r[i] <= 16'sd0;
        dh_r[i]   <= HIST_RESET;
      end
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && paddr == ADDR_WIDE_MODE[2:0]) mode_r <= pwdata[0];
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (do_final) out_valid_r <= 1'b1;
      if (do_adapt) k_r <= 3'd0;
      if (do_mac) k_r <= k_r + 3'd1;
      if (do_adapt) begin
        slow_r    <= slow_nxt;
        fast_r    <= fast_nxt;
        se_r      <= se_nxt;
        le_r      <= le_nxt;
        sp_r      <= sp_nxt;
        tone_r    <= tone_nxt;
        pole_r    <= pole_nxt;
        zero_r    <= zero_nxt;
        ps_r[1]   <= ps_r[0];
        ps_r[0]   <= dqsez_r[16];
        sh_r[1]   <= sh_r[0];
        sh_r[0]   <= sh0_nxt;
        for (int i = 5; i > 0; i--) dh_r[i] <= dh_r[i - 1];
        dh_r[0]   <= dh0_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      dq_r    <= in_diff_quantized;
      sr_r    <= in_recon_signal;
      dqsez_r <= in_diff_plus_zero_est;
      wi_r    <= in_scale_multiplier;
      fi_r    <= in_speed_term;
    end
    if (do_step) y_r <= y_cur;
    if (do_adapt) begin
      zs_r   <= 19'sd0;
      pacc_r <= 17'sd0;
    end
    if (do_mac) begin
      if (k_r < NUM_ZEROS) zs_r <= zs_r + $signed({{3{mac_prod[15]}}, mac_prod});
      else pacc_r <= pacc_r + $signed({mac_prod[15], mac_prod});
    end
    if (do_final) begin
      out_step_r <= y_cur;
      out_zs_r   <= zs_r;
      out_ps_r   <= pacc_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quant_step = out_step_r;
  assign out_zero_sum   = out_zs_r;
  assign out_pole_sum   = out_ps_r;
  assign pready         = 1'b1;
  assign prdata         = (paddr == ADDR_WIDE_MODE[2:0]) ? {31'b0, mode_r} : 32'd0;

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE || out_valid_r) |-> !in_ready) else $error("ready while busy");
  a_fast_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fast_r >= FAST_MIN && fast_r <= FAST_MAX)) else $error("fast scale out of range");
  a_mac_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL) |-> ($past(state_r) == ST_MAC && $past(k_r) == MAC_LAST))
    else $error("short product sweep");
`endif

endmodule

// ===== bench/adpcm_predictor_adaptation_unit_tb.sv =====
module adpcm_predictor_adaptation_unit_tb;
  import apau_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [12:0] quant_step;
    logic [18:0] zero_sum;
    logic [16:0] pole_sum;
  } adapt_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_diff_quantized;
  logic signed [15:0] in_recon_signal;
  logic signed [16:0] in_diff_plus_zero_est;
  logic signed [13:0] in_scale_multiplier;
  logic        [11:0] in_speed_term;
  logic               out_valid;
  logic               out_ready;
  logic        [12:0] out_quant_step;
  logic signed [18:0] out_zero_sum;
  logic signed [16:0] out_pole_sum;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [2:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;

  adpcm_predictor_adaptation_unit uut (.*);

  // predictor state
  int mdl_wide;
  int mdl_slow;
  int mdl_fast;
  int mdl_sht;
  int mdl_lng;
  int mdl_spd;
  int mdl_apole [2];
  int mdl_bzero [6];
  int mdl_psign [2];
  int mdl_srhist [2];
  int mdl_dqhist [6];
  int mdl_tone;

  adapt_result_t pending_results[$];
  int            n_sent;
  int            n_checked;
  int            n_errors;
  int            n_transitions;
  int            n_tone_items;
  int            cycle_cnt;
  int            hold_cycles;
  int            rdy_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sx16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic int bit_len(int v);
    int i;
    i = 0;
    while (i < 15 && v >= (1 << i)) i++;
    return i;
  endfunction

  function automatic int float_of(bit neg, int mag);
    int e;
    int f;
    if (mag == 0) return neg ? sx16(FLOAT_NEG_ZERO) : 32;
    e = bit_len(mag);
    f = (e << 6) + ((mag << 6) >> e);
    return neg ? sx16(f - 1024) : f;
  endfunction

  function automatic int float_mul(int an, int srn);
    int mag;
    int ex;
    int mant;
    int wex;
    int wmant;
    int r;
    logic [31:0] s;
    s = srn;
    mag = (an > 0) ? an : ((-an) & 'h1FFF);
    ex = bit_len(mag) - 6;
    if (mag == 0) mant = 32;
    else mant = (ex >= 0) ? (mag >> ex) : (mag << (-ex));
    wex = ex + int'(s[9:6]) - 13;
    wmant = (mant * int'(s[5:0]) + 48) >> 4;
    r = (wex >= 0) ? ((wmant << wex) & 'h7FFF) : (wmant >> (-wex));
    return ((an < 0) != (srn < 0)) ? -r : r;
  endfunction

  function automatic int step_now();
    int y;
    int dif;
    int al;
    if (mdl_spd >= 256) return mdl_fast;
    y = mdl_slow >> 6;
    dif = mdl_fast - y;
    al = mdl_spd >> 2;
    if (dif > 0) y += (dif * al) >> 6;
    else if (dif < 0) y += (dif * al + 63) >>> 6;
    return y;
  endfunction

  task automatic reset_model();
    mdl_wide = 0;
    mdl_slow = 34816;
    mdl_fast = 544;
    mdl_sht = 0;
    mdl_lng = 0;
    mdl_spd = 0;
    mdl_tone = 0;
    for (int i = 0; i < 2; i++) begin
      mdl_apole[i] = 0;
      mdl_psign[i] = 0;
      mdl_srhist[i] = 32;
    end
    for (int i = 0; i < 6; i++) begin
      mdl_bzero[i] = 0;
      mdl_dqhist[i] = 32;
    end
  endtask

  function automatic adapt_result_t adapt_sample(logic [15:0] dq_b, logic [15:0] sr_b,
                                                 logic [16:0] ds_b, logic [13:0] wi_b,
                                                 logic [11:0] fi_b);
    adapt_result_t res;
    int dq;
    int sr;
    int dqsez;
    int wi;
    int fi;
    int y;
    int mag;
    int pk0;
    int ylint;
    int ylfrac;
    int thr;
    int dqthr;
    int a2p;
    int a0;
    int pks1;
    int fa1;
    int a1ul;
    int b;
    int d;
    int zs;
    int ps;
    bit tr;
    dq = int'($signed(dq_b));
    sr = int'($signed(sr_b));
    dqsez = int'($signed(ds_b));
    wi = int'($signed(wi_b));
    fi = int'(fi_b);
    y = step_now();
    mag = dq & 'h7FFF;
    pk0 = (dqsez < 0) ? 1 : 0;
    a2p = 0;

    ylint = mdl_slow >> 15;
    ylfrac = (mdl_slow >> 10) & 'h1F;
    thr = (ylint > 9) ? (31 << 10) : ((32 + ylfrac) << ylint);
    dqthr = (thr + (thr >> 1)) >> 1;
    tr = (mdl_tone != 0) && (mag > dqthr);
    if (tr) n_transitions++;
    if (mdl_tone != 0) n_tone_items++;

    mdl_fast = y + ((wi - y) >>> 5);
    if (mdl_fast < 544) mdl_fast = 544;
    else if (mdl_fast > 5120) mdl_fast = 5120;
    mdl_slow = (mdl_slow + mdl_fast - ((mdl_slow + 63) >> 6)) & 'h7FFFF;

    if (tr) begin
      mdl_apole[0] = 0;
      mdl_apole[1] = 0;
      for (int i = 0; i < 6; i++) mdl_bzero[i] = 0;
    end else begin
      pks1 = pk0 ^ mdl_psign[0];
      a0 = mdl_apole[0];
      a2p = mdl_apole[1] - (mdl_apole[1] >>> 7);
      if (dqsez != 0) begin
        fa1 = pks1 ? a0 : -a0;
        if (fa1 < -8191) a2p -= 'h100;
        else if (fa1 > 8191) a2p += 'hFF;
        else a2p += fa1 >>> 5;
        if (pk0 ^ mdl_psign[1]) begin
          if (a2p <= -12160) a2p = -12288;
          else if (a2p >= 12416) a2p = 12288;
          else a2p -= 'h80;
        end else begin
          if (a2p <= -12416) a2p = -12288;
          else if (a2p >= 12160) a2p = 12288;
          else a2p += 'h80;
        end
      end
      a2p = sx16(a2p);
      mdl_apole[1] = a2p;
      a0 -= a0 >>> 8;
      if (dqsez != 0) a0 += pks1 ? -192 : 192;
      a1ul = 15360 - a2p;
      if (a0 < -a1ul) a0 = -a1ul;
      else if (a0 > a1ul) a0 = a1ul;
      mdl_apole[0] = sx16(a0);
      for (int i = 0; i < 6; i++) begin
        b = mdl_bzero[i];
        b -= b >>> (mdl_wide ? 9 : 8);
        if (mag != 0) b += ((dq < 0) == (mdl_dqhist[i] < 0)) ? 128 : -128;
        mdl_bzero[i] = sx16(b);
      end
    end

    for (int i = 5; i > 0; i--) mdl_dqhist[i] = mdl_dqhist[i - 1];
    mdl_dqhist[0] = float_of(dq < 0, mag);
    mdl_srhist[1] = mdl_srhist[0];
    if (sr == -32768) mdl_srhist[0] = sx16(FLOAT_NEG_ZERO);
    else mdl_srhist[0] = float_of(sr < 0, (sr < 0) ? -sr : sr);
    mdl_psign[1] = mdl_psign[0];
    mdl_psign[0] = pk0;

    if (tr) mdl_tone = 0;
    else mdl_tone = (a2p < -11776) ? 1 : 0;

    mdl_sht = sx16(mdl_sht + ((fi - mdl_sht) >>> 5));
    mdl_lng = sx16(mdl_lng + (((fi << 2) - mdl_lng) >>> 7));
    d = (mdl_sht << 2) - mdl_lng;
    if (d < 0) d = -d;
    if (tr) mdl_spd = 256;
    else if (y < 1536 || mdl_tone == 1 || d >= (mdl_lng >>> 3))
      mdl_spd += ('h200 - mdl_spd) >>> 4;
    else mdl_spd += (-mdl_spd) >>> 4;
    mdl_spd &= 'h3FF;

    zs = 0;
    for (int i = 0; i < 6; i++) zs += float_mul(mdl_bzero[i] >>> 2, mdl_dqhist[i]);
    ps = float_mul(mdl_apole[1] >>> 2, mdl_srhist[1]) +
         float_mul(mdl_apole[0] >>> 2, mdl_srhist[0]);

    res.quant_step = 13'(step_now());
    res.zero_sum = 19'(zs);
    res.pole_sum = 17'(ps);
    return res;
  endfunction

  // one beat on the sample channel; valid stays high on return
  task automatic send_sample(logic [15:0] dq, logic [15:0] sr, logic [16:0] ds,
                             logic [13:0] wi, logic [11:0] fi);
    in_diff_quantized = dq;
    in_recon_signal = sr;
    in_diff_plus_zero_est = ds;
    in_scale_multiplier = wi;
    in_speed_term = fi;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(adapt_sample(dq, sr, ds, wi, fi));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_mode(int v);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_WIDE_MODE[2:0];
    pwdata = v;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    mdl_wide = v & 1;
  endtask

  task automatic send_random();
    logic [15:0] dq;
    logic [15:0] sr;
    logic [16:0] ds;
    dq = 16'($urandom);
    if ($urandom_range(0, 2) == 0) dq[14:0] = 15'($urandom_range(0, 255));
    sr = 16'($urandom);
    ds = 17'($urandom);
    if ($urandom_range(0, 9) == 0) ds = '0;
    send_sample(dq, sr, ds, 14'($urandom), 12'($urandom));
  endtask

  task automatic test_directed();
    send_sample(16'h0000, 16'h0000, 17'h00000, 14'h0000, 12'h000);
    send_sample(16'h8000, 16'h8000, 17'h10000, 14'h2000, 12'hFFF);
    send_sample(16'h7FFF, 16'h7FFF, 17'h0FFFF, 14'h1FFF, 12'h000);
    send_sample(16'hFFFF, 16'hFFFF, 17'h1FFFF, 14'h3FFF, 12'hFFF);
    send_sample(16'h8000, 16'h0001, 17'h00001, 14'h0000, 12'h800);
    send_sample(16'h0001, 16'h8001, 17'h00000, 14'h1FFF, 12'h7FF);
    for (int i = 0; i < 10; i++)
      send_sample(16'h4000, 16'h4000, 17'h00100, 14'h1FFF, 12'hFFF);
  endtask

  // sign pattern ++-- drags the second pole down into tone territory
  task automatic test_tone_then_transition(int runs);
    for (int r = 0; r < runs; r++) begin
      for (int i = 0; i < 90; i++)
        send_sample({$urandom_range(0, 1) == 1, 15'($urandom_range(0, 31))}, 16'($urandom),
                    (i % 4) < 2 ? 17'($urandom_range(1, 65535)) : 17'h10000 | 17'($urandom),
                    14'($urandom_range(0, 600)), 12'($urandom));
      send_sample({1'($urandom), 15'h7FFF}, 16'($urandom), 17'($urandom), 14'($urandom),
                  12'($urandom));
      if ($urandom_range(0, 1) == 1) idle_sender($urandom_range(0, 6));
    end
  endtask

  // steady same-sign differences walk the zero coefficients to the wrap point
  task automatic test_coeff_wrap(int n);
    for (int i = 0; i < n; i++)
      send_sample(16'h0040, 16'h0100, 17'h00000, 14'h0000, 12'h100);
    for (int i = 0; i < 20; i++)
      send_sample(16'h8040, 16'hF000, 17'h10000, 14'h0000, 12'h100);
  endtask

  task automatic test_random(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_random();
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 20));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 12; i++) send_random();
    wait_drained();
    for (int i = 0; i < 8; i++) send_random();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (rdy_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        default: out_ready <= (cycle_cnt % 5) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 97 == 0) rdy_mode <= $urandom_range(0, 2);
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        adapt_result_t exp_r;
        exp_r = pending_results.pop_front();
        if (out_quant_step !== exp_r.quant_step) begin
          $error("quant_step exp %0d got %0d", exp_r.quant_step, out_quant_step);
          n_errors++;
        end
        if (out_zero_sum !== exp_r.zero_sum) begin
          $error("zero_sum exp %0d got %0d", $signed(exp_r.zero_sum), out_zero_sum);
          n_errors++;
        end
        if (out_pole_sum !== exp_r.pole_sum) begin
          $error("pole_sum exp %0d got %0d", $signed(exp_r.pole_sum), out_pole_sum);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_diff_quantized = '0;
    in_recon_signal = '0;
    in_diff_plus_zero_est = '0;
    in_scale_multiplier = '0;
    in_speed_term = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    n_transitions = 0;
    n_tone_items = 0;
    cycle_cnt = 0;
    hold_cycles = 0;
    rdy_mode = 0;
    reset_model();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    write_mode(1);
    test_directed();
    test_coeff_wrap(300);
    write_mode(0);
    test_coeff_wrap(250);
    test_tone_then_transition(3);
    test_backpressure();
    write_mode(1);
    test_random(200);
    test_tone_then_transition(1);
    write_mode(0);
    test_random(100);

    wait_drained();
    repeat (20) @(negedge clk);
    $display("samples sent %0d, results checked %0d, both leak modes", n_sent, n_checked);
    $display("tone-flagged samples %0d, transitions detected %0d", n_tone_items,
             n_transitions);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/apau_pkg.sv
hw/rtl/adpcm_predictor_adaptation_unit.sv
bench/adpcm_predictor_adaptation_unit_tb.sv
